// File: hw/rtl/srw_pkg.sv
// Shared types and constants for the selective-repeat receive window.
// Used by the controller, the datapath and the top level.
package srw_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int SEQ_W      = 32;
  localparam int LEN_W      = 10;
  localparam int WIN_W      = 6;
  localparam int MAP_W      = 32;
  localparam int IDX_W      = $clog2(MAP_W);
  localparam int IN_W       = 48;  // seq + len, padded to whole bytes
  localparam int OUT_W      = 64;  // ack_base + selective_acks
  localparam int USER_W     = 2;   // accepted, complete

  localparam logic [LEN_W-1:0] FULL_PAYLOAD = LEN_W'(1000);
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);
  localparam logic [WIN_W-1:0] WINDOW_MIN   = WIN_W'(1);
  localparam logic [WIN_W-1:0] WINDOW_MAX   = WIN_W'(MAX_WINDOW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ADVANCE,
    ST_EMIT
  } srw_state_t;

  typedef struct packed {
    logic load_in;   // capture an accepted segment
    logic eval;      // window test, final mark, bitmap set
    logic step;      // advance base by one and shift bitmap
    logic load_out;  // move the ack into the output register
  } srw_cmd_t;

  typedef struct packed {
    logic base_hit;  // segment is the one at the window base
    logic more;      // next base already received
  } srw_sts_t;

endpackage

// File: hw/rtl/srw_ctrl.sv
// Controller state machine for the selective-repeat receive window.
// Depends on srw_pkg; drives the datapath through srw_cmd_t.
module srw_ctrl
  import srw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  srw_sts_t sts,
  output srw_cmd_t cmd
);

  srw_state_t state, state_next;
  logic       out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.base_hit ? ST_ADVANCE : ST_EMIT;
      end
      ST_ADVANCE: begin
        // keep stepping while the new base was already received
        cmd.step = 1'b1;
        if (!sts.more) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_full || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.load_out) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  assign m_tvalid = out_full;

endmodule

// File: hw/rtl/srw_dp.sv
// Datapath for the selective-repeat receive window: window state,
// bitmap, last-segment tracking and the output register. Depends on srw_pkg.
module srw_dp
  import srw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [WIN_W-1:0]  cfg_data,
  input  logic [IN_W-1:0]   s_tdata,
  input  srw_cmd_t          cmd,
  output srw_sts_t          sts,
  output logic [OUT_W-1:0]  m_tdata,
  output logic [USER_W-1:0] m_tuser
);

  logic [WIN_W-1:0]  window_size;
  logic [SEQ_W-1:0]  win_base;
  logic [MAP_W-1:0]  received_map;
  logic [SEQ_W-1:0]  final_seq;
  logic              final_known;
  logic              accepted;

  logic [SEQ_W-1:0]  seq;
  logic [LEN_W-1:0]  len;

  logic [WIN_W-1:0]  eff_window;
  logic [SEQ_W-1:0]  offset;
  logic [SEQ_W-1:0]  offset_m1;
  logic              in_window;
  logic              complete;

  // clamp the window register into 1..MAX_WINDOW
  always_comb begin
    if (window_size < WINDOW_MIN) begin
      eff_window = WINDOW_MIN;
    end else if (window_size > WINDOW_MAX) begin
      eff_window = WINDOW_MAX;
    end else begin
      eff_window = window_size;
    end
  end

  assign offset    = seq - win_base;
  assign offset_m1 = offset - SEQ_W'(1);
  assign in_window = offset < {{(SEQ_W-WIN_W){1'b0}}, eff_window};
  assign complete  = final_known && (win_base > final_seq);

  assign sts.base_hit = in_window && (offset == '0);
  assign sts.more     = received_map[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (cfg_valid) begin
      window_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      seq <= s_tdata[SEQ_W-1:0];
      len <= s_tdata[SEQ_W+LEN_W-1:SEQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_base     <= '0;
      received_map <= '0;
      final_seq    <= '0;
      final_known  <= 1'b0;
      accepted     <= 1'b0;
    end else if (cmd.eval) begin
      if (len < FULL_PAYLOAD) begin
        final_seq   <= seq;
        final_known <= 1'b1;
      end
      accepted <= in_window;
      if (in_window && (offset != '0)) begin
        received_map <= received_map | (MAP_W'(1) << offset_m1[IDX_W-1:0]);
      end
    end else if (cmd.step) begin
      win_base     <= win_base + SEQ_W'(1);
      received_map <= received_map >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {received_map, win_base};
      m_tuser <= {complete, accepted};
    end
  end

endmodule

// File: hw/rtl/selective_repeat_receive_window.sv
// Top level of the selective-repeat receive window.
// Depends on srw_pkg, srw_ctrl and srw_dp.
//   Slave side: one beat per arriving segment. s_tdata[31:0] is the
//   sequence number, s_tdata[41:32] the payload length (below 1000 marks
//   the last segment), s_tdata[47:42] zero.
//   Master side: one ack beat per segment. m_tdata[31:0] is the window
//   base, m_tdata[63:32] the selective-ack bitmap (bit 0 = base + 1);
//   m_tuser[0] says the segment was accepted, m_tuser[1] that the transfer
//   is complete.
//   Config: a cfg_valid/cfg_ready beat writes the 6-bit window size
//   (0 acts as 1, above 32 acts as 32). Write it only while idle.
// Timing: one segment at a time. An out-of-window segment or one above the
//   base goes from accept through EVAL to EMIT, where the ack is loaded.
//   A segment at the base passes through ADVANCE, which walks the base
//   forward one position a cycle through the run of received segments,
//   before EMIT. EMIT waits while a stalled ack holds the output register.
// Reset: rst clears base, bitmap and last-segment state, sets the window
//   to 8 and drops m_tvalid. A stalled master side holds its beat; the
//   block still accepts the next segment and parks its ack until the
//   register frees up.
module selective_repeat_receive_window
  import srw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [WIN_W-1:0]  cfg_data,   // window_size
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,    // segment_seq, payload_bytes, pad
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,    // ack_base, sack_map
  output logic [USER_W-1:0] m_tuser     // accepted, complete
);

  srw_cmd_t cmd;
  srw_sts_t sts;

  // config register is always writable
  assign cfg_ready = 1'b1;

  srw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// File: hw/rtl/srw_checker.sv
// Port-level checks for the selective-repeat receive window.
// Depends on srw_pkg; bound to the top level below.
module srw_checker
  import srw_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_W-1:0]  m_tdata,
  input logic [USER_W-1:0] m_tuser
);

  // no ack beat right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("ack valid after reset");

  // a stalled ack beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled ack changed");

  // one segment in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("segment accepted while busy");

  // the window never reaches past base + 31, so the top bitmap bit stays clear
  a_map_top: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[OUT_W-1])
    else $error("bitmap bit beyond window set");

endmodule

bind selective_repeat_receive_window srw_checker u_srw_checker (.*);
